// ----- hw/rtl/mls_pkg.sv -----
// ----------------------------------------------------------------------------
// mls_pkg
// Shared widths, codes and types of the midpoint line stepper.
// ----------------------------------------------------------------------------
package mls_pkg;

   localparam int COORD_BITS = 12;
   localparam int FRAME_BITS = 11;
   localparam int COLOR_BITS = 32;
   localparam int DX_BITS    = COORD_BITS + 1;
   localparam int DEC_BITS   = COORD_BITS + 3;
   localparam int CMP_BITS   = ((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS) + 1;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = FRAME_BITS'(640);
   localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = FRAME_BITS'(480);

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] span_type;
   typedef logic signed [DEC_BITS-1:0]   decision_type;
   typedef logic        [FRAME_BITS-1:0] frame_type;
   typedef logic        [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      span_type     major_delta;
      span_type     minor_delta;
      logic         x_negative;
      logic         y_negative;
      logic         steep;
      decision_type decision;
   } line_setup_type;

endpackage

// ----- hw/rtl/mls_req_if.sv -----
// ----------------------------------------------------------------------------
// mls_req_if
// Request channel: start or advance words with endpoints and colour.
// ----------------------------------------------------------------------------
interface mls_req_if;
   logic                valid;
   logic                ready;
   logic                req_type;
   mls_pkg::coord_type  x_start;
   mls_pkg::coord_type  y_start;
   mls_pkg::coord_type  x_end;
   mls_pkg::coord_type  y_end;
   mls_pkg::color_type  line_color;

   modport source (output valid, req_type, x_start, y_start, x_end, y_end, line_color,
                   input ready);
   modport sink   (input valid, req_type, x_start, y_start, x_end, y_end, line_color,
                   output ready);
endinterface

// ----- hw/rtl/mls_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mls_rsp_if
// Result channel: one line point word per request.
// ----------------------------------------------------------------------------
interface mls_rsp_if;
   logic                valid;
   logic                ready;
   mls_pkg::coord_type  pixel_x;
   mls_pkg::coord_type  pixel_y;
   mls_pkg::color_type  pixel_color;
   logic                write_enable;
   logic                point_valid;
   logic                last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, write_enable, point_valid,
                   last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, write_enable, point_valid,
                   last, output ready);
endinterface

// ----- hw/rtl/mls_line_setup.sv -----
// ----------------------------------------------------------------------------
// mls_line_setup
// Spans, directions, major axis and initial decision term of a new line.
// ----------------------------------------------------------------------------
module mls_line_setup (
   input  mls_pkg::coord_type      x_start,
   input  mls_pkg::coord_type      y_start,
   input  mls_pkg::coord_type      x_end,
   input  mls_pkg::coord_type      y_end,
   output mls_pkg::line_setup_type setup
);

   logic signed [mls_pkg::DX_BITS-1:0] dx;
   logic signed [mls_pkg::DX_BITS-1:0] dy;
   mls_pkg::span_type                  adx;
   mls_pkg::span_type                  ady;
   mls_pkg::span_type                  major;
   mls_pkg::span_type                  minor;
   logic                               steep;

   assign dx  = mls_pkg::DX_BITS'(x_end) - mls_pkg::DX_BITS'(x_start);
   assign dy  = mls_pkg::DX_BITS'(y_end) - mls_pkg::DX_BITS'(y_start);
   assign adx = dx[mls_pkg::DX_BITS-1] ? mls_pkg::COORD_BITS'(-dx) : mls_pkg::COORD_BITS'(dx);
   assign ady = dy[mls_pkg::DX_BITS-1] ? mls_pkg::COORD_BITS'(-dy) : mls_pkg::COORD_BITS'(dy);

   // equal spans keep x as the major axis
   assign steep = ady > adx;
   assign major = steep ? ady : adx;
   assign minor = steep ? adx : ady;

   always_comb begin
      setup.major_delta = major;
      setup.minor_delta = minor;
      setup.x_negative  = dx[mls_pkg::DX_BITS-1];
      setup.y_negative  = dy[mls_pkg::DX_BITS-1];
      setup.steep       = steep;
      setup.decision    = $signed(mls_pkg::DEC_BITS'({minor, 1'b0}))
                        - $signed(mls_pkg::DEC_BITS'(major));
   end

endmodule

// ----- hw/rtl/mls_clip.sv -----
// ----------------------------------------------------------------------------
// mls_clip
// Frame test: a point is inside when 0 <= x < width and 0 <= y < height.
// ----------------------------------------------------------------------------
module mls_clip (
   input  mls_pkg::coord_type pt_x,
   input  mls_pkg::coord_type pt_y,
   input  mls_pkg::frame_type frame_width,
   input  mls_pkg::frame_type frame_height,
   output logic               in_frame
);

   logic x_in;
   logic y_in;

   assign x_in = !pt_x[mls_pkg::COORD_BITS-1] &&
                 (mls_pkg::CMP_BITS'($unsigned(pt_x)) < mls_pkg::CMP_BITS'(frame_width));
   assign y_in = !pt_y[mls_pkg::COORD_BITS-1] &&
                 (mls_pkg::CMP_BITS'($unsigned(pt_y)) < mls_pkg::CMP_BITS'(frame_height));
   assign in_frame = x_in && y_in;

endmodule

// ----- hw/rtl/midpoint_line_stepper.sv -----
// ----------------------------------------------------------------------------
// midpoint_line_stepper
// Midpoint line stepper: a start word loads a line and gives its first point,
// each advance word gives the next point, clipped against the frame.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          carries
//   req_bus   in   valid / ready      req_type, endpoints, line_color
//   rsp_bus   out  valid / ready      point, colour, write_enable, point_valid, last
//   csr_*     in   csr_we (no wait)   frame_width (index 0), frame_height (index 1)
//
// One request word per clock sustained while results are taken; each gives one
// result word (input register, then result register, loaded with the line state).
// The per-word work is one add on the decision term and one add per axis.
// Reset (synchronous) empties both registers, goes idle and restores a
// 640 x 480 frame. A stalled result holds the step stage; the input register
// still takes one more word if it is empty, then ready drops.
// ----------------------------------------------------------------------------
module midpoint_line_stepper (
   input  logic                                  clock,
   input  logic                                  reset,
   mls_req_if.sink                               req_bus,
   mls_rsp_if.source                             rsp_bus,
   input  logic                                  csr_we,
   input  logic [mls_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mls_pkg::FRAME_BITS-1:0]        csr_wdata
);

   // frame registers
   mls_pkg::frame_type frame_width_ff;
   mls_pkg::frame_type frame_height_ff;

   // input register
   logic               in_vld_ff;
   logic               req_type_ff;
   mls_pkg::coord_type x_start_ff;
   mls_pkg::coord_type y_start_ff;
   mls_pkg::coord_type x_end_ff;
   mls_pkg::coord_type y_end_ff;
   mls_pkg::color_type line_color_ff;

   // line state
   logic                   active_ff,      active_in;
   mls_pkg::coord_type     cur_x_ff,       cur_x_in;
   mls_pkg::coord_type     cur_y_ff,       cur_y_in;
   mls_pkg::decision_type  decision_ff,    decision_in;
   mls_pkg::span_type      steps_left_ff,  steps_left_in;
   mls_pkg::span_type      major_delta_ff, major_delta_in;
   mls_pkg::span_type      minor_delta_ff, minor_delta_in;
   logic                   x_negative_ff,  x_negative_in;
   logic                   y_negative_ff,  y_negative_in;
   logic                   steep_ff,       steep_in;
   mls_pkg::color_type     held_color_ff,  held_color_in;

   // result register
   logic                   out_vld_ff;
   mls_pkg::coord_type     pixel_x_ff,      pixel_x_in;
   mls_pkg::coord_type     pixel_y_ff,      pixel_y_in;
   mls_pkg::color_type     pixel_color_ff,  pixel_color_in;
   logic                   write_enable_ff, write_enable_in;
   logic                   point_valid_ff,  point_valid_in;
   logic                   last_ff,         last_in;

   logic                    step_go;
   mls_pkg::line_setup_type setup;
   logic                    in_frame;
   logic                    minor_step;
   logic                    step_x;
   logic                    step_y;
   mls_pkg::coord_type      x_unit;
   mls_pkg::coord_type      y_unit;
   mls_pkg::decision_type   dec_incr;

   // advance the step stage when it holds a word and the result slot frees
   assign step_go       = in_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !in_vld_ff || step_go;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mls_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= mls_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mls_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            mls_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         req_type_ff   <= req_bus.req_type;
         x_start_ff    <= req_bus.x_start;
         y_start_ff    <= req_bus.y_start;
         x_end_ff      <= req_bus.x_end;
         y_end_ff      <= req_bus.y_end;
         line_color_ff <= req_bus.line_color;
      end
   end

   // ----------------------------------------------------------- step stage
   mls_line_setup u_setup (
      .x_start (x_start_ff),
      .y_start (y_start_ff),
      .x_end   (x_end_ff),
      .y_end   (y_end_ff),
      .setup   (setup)
   );

   // minor axis steps while the decision term is strictly positive
   assign minor_step = !decision_ff[mls_pkg::DEC_BITS-1] && (decision_ff != '0);
   assign step_x     = steep_ff ? minor_step : 1'b1;
   assign step_y     = steep_ff ? 1'b1 : minor_step;
   assign x_unit     = x_negative_ff ? {mls_pkg::COORD_BITS{1'b1}} : mls_pkg::COORD_BITS'(1);
   assign y_unit     = y_negative_ff ? {mls_pkg::COORD_BITS{1'b1}} : mls_pkg::COORD_BITS'(1);
   assign dec_incr   = $signed(mls_pkg::DEC_BITS'({minor_delta_ff, 1'b0}))
                     - (minor_step ? $signed(mls_pkg::DEC_BITS'({major_delta_ff, 1'b0}))
                                   : $signed(mls_pkg::DEC_BITS'(0)));

   always_comb begin
      active_in      = active_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      decision_in    = decision_ff;
      steps_left_in  = steps_left_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      x_negative_in  = x_negative_ff;
      y_negative_in  = y_negative_ff;
      steep_in       = steep_ff;
      held_color_in  = held_color_ff;

      if (req_type_ff == mls_pkg::REQ_START) begin
         // drop any line in flight and load the new one
         major_delta_in = setup.major_delta;
         minor_delta_in = setup.minor_delta;
         x_negative_in  = setup.x_negative;
         y_negative_in  = setup.y_negative;
         steep_in       = setup.steep;
         decision_in    = setup.decision;
         steps_left_in  = setup.major_delta;
         cur_x_in       = x_start_ff;
         cur_y_in       = y_start_ff;
         held_color_in  = line_color_ff;
         active_in      = setup.major_delta != '0;
      end else if (active_ff) begin
         if (step_x) cur_x_in = cur_x_ff + x_unit;
         if (step_y) cur_y_in = cur_y_ff + y_unit;
         decision_in   = decision_ff + dec_incr;
         steps_left_in = steps_left_ff - mls_pkg::COORD_BITS'(1);
         active_in     = steps_left_ff != mls_pkg::COORD_BITS'(1);
      end
   end

   mls_clip u_clip (
      .pt_x         (cur_x_in),
      .pt_y         (cur_y_in),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .in_frame     (in_frame)
   );

   // an advance while idle gives an all-zero word with point_valid low
   always_comb begin
      if ((req_type_ff == mls_pkg::REQ_START) || active_ff) begin
         pixel_x_in      = cur_x_in;
         pixel_y_in      = cur_y_in;
         pixel_color_in  = held_color_in;
         write_enable_in = in_frame;
         point_valid_in  = 1'b1;
         last_in         = !active_in;
      end else begin
         pixel_x_in      = '0;
         pixel_y_in      = '0;
         pixel_color_in  = '0;
         write_enable_in = 1'b0;
         point_valid_in  = 1'b0;
         last_in         = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (step_go) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         decision_ff    <= decision_in;
         steps_left_ff  <= steps_left_in;
         major_delta_ff <= major_delta_in;
         minor_delta_ff <= minor_delta_in;
         x_negative_ff  <= x_negative_in;
         y_negative_ff  <= y_negative_in;
         steep_ff       <= steep_in;
         held_color_ff  <= held_color_in;
      end
   end

   // --------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (step_go) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         pixel_x_ff      <= pixel_x_in;
         pixel_y_ff      <= pixel_y_in;
         pixel_color_ff  <= pixel_color_in;
         write_enable_ff <= write_enable_in;
         point_valid_ff  <= point_valid_in;
         last_ff         <= last_in;
      end
   end

   assign rsp_bus.valid        = out_vld_ff;
   assign rsp_bus.pixel_x      = pixel_x_ff;
   assign rsp_bus.pixel_y      = pixel_y_ff;
   assign rsp_bus.pixel_color  = pixel_color_ff;
   assign rsp_bus.write_enable = write_enable_ff;
   assign rsp_bus.point_valid  = point_valid_ff;
   assign rsp_bus.last         = last_ff;

   // ----------------------------------------------------------- assertions
   // after a step the line is live exactly when the word just made is a
   // point that is not the last
   a_active_tracks_last : assert property (@(posedge clock) disable iff (reset)
      step_go |=> (active_ff == (point_valid_ff && !last_ff)))
      else $error("line state disagrees with the last flag of the result");

   a_active_has_steps : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (steps_left_ff != '0))
      else $error("line live with no steps left");

   a_we_needs_point : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (!write_enable_ff || point_valid_ff))
      else $error("write enable on a word with no point");

   a_step_fills_out : assert property (@(posedge clock) disable iff (reset)
      step_go |=> out_vld_ff)
      else $error("step taken but result register empty");

endmodule
